// ----- design/dmc_pkg.sv -----
// ----------------------------------------------------------------------------
// dmc_pkg
// shared types and constants of the direct-mapped write-back cache tag block
// ----------------------------------------------------------------------------
package dmc_pkg;

	localparam int BYTE_ADDR_W   = 32;
	localparam int INSTR_CNT_W   = 16;
	localparam int ACC_CYC_W     = 11;
	localparam int MEM_SUM_W     = 48;
	localparam int STAT_W        = 32;

	localparam int CFG_IDX_W     = 2;
	localparam int CFG_DATA_W    = 10;

	// register indexes of the configuration port
	localparam logic [CFG_IDX_W-1:0] CFG_BLOCK_OFFSET  = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_INDEX_BITS    = 2'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_MISS_PENALTY  = 2'd2;

	localparam logic [2:0] RST_BLOCK_OFFSET = 3'd4;
	localparam logic [3:0] RST_INDEX_BITS   = 4'd10;
	localparam logic [9:0] RST_MISS_PENALTY = 10'd30;

	localparam logic [2:0] MIN_OFFSET_BITS  = 3'd2;
	localparam logic [ACC_CYC_W-1:0] WB_EXTRA_CYCLES = 11'd2;

	typedef struct packed {
		logic                   is_store;
		logic [BYTE_ADDR_W-1:0] byte_address;
		logic [INSTR_CNT_W-1:0] instr_count;
	} cmd_t;

	typedef struct packed {
		logic                 hit;
		logic                 write_back;
		logic [ACC_CYC_W-1:0] access_cycles;
		logic [MEM_SUM_W-1:0] cycle_total;
		logic [STAT_W-1:0]    instr_sum;
		logic [STAT_W-1:0]    total_accesses;
		logic [STAT_W-1:0]    load_miss_count;
		logic [STAT_W-1:0]    store_miss_count;
		logic [STAT_W-1:0]    load_hit_count;
		logic [STAT_W-1:0]    store_hit_count;
		logic [STAT_W-1:0]    dirty_eviction_count;
	} result_t;

	// outcome of one lookup, handed to the statistics unit
	typedef struct packed {
		logic                   fire;
		logic                   is_store;
		logic                   hit;
		logic                   write_back;
		logic [ACC_CYC_W-1:0]   cycles;
		logic [INSTR_CNT_W-1:0] instr_count;
	} stat_ev_t;

	typedef struct packed {
		logic [MEM_SUM_W-1:0] cycle_sum;
		logic [STAT_W-1:0]    instructions;
		logic [STAT_W-1:0]    accesses;
		logic [STAT_W-1:0]    load_miss;
		logic [STAT_W-1:0]    store_miss;
		logic [STAT_W-1:0]    load_hit;
		logic [STAT_W-1:0]    store_hit;
		logic [STAT_W-1:0]    dirty_evict;
	} stat_tot_t;

	function automatic logic [STAT_W-1:0] sat_add32(input logic [STAT_W-1:0] a,
	                                                input logic [STAT_W-1:0] b);
		logic [STAT_W:0] s;
		s = {1'b0, a} + {1'b0, b};
		return s[STAT_W] ? {STAT_W{1'b1}} : s[STAT_W-1:0];
	endfunction

endpackage

// ----- design/dmc_ram.sv -----
// ----------------------------------------------------------------------------
// dmc_ram
// simple dual-port ram, one write port, one registered read port
// ----------------------------------------------------------------------------
module dmc_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 1024
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

// ----- design/dmc_stats.sv -----
// ----------------------------------------------------------------------------
// dmc_stats
// saturating running totals of memory cycles, instructions, hit/miss and dirty eviction counts
// ----------------------------------------------------------------------------
module dmc_stats import dmc_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  stat_ev_t  ev,
	output stat_tot_t tot
);

	stat_tot_t       tot_q;
	logic [MEM_SUM_W:0] mem_sum;

	assign mem_sum = {1'b0, tot_q.cycle_sum} + (MEM_SUM_W+1)'(ev.cycles);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tot_q <= '0;
		end else if (ev.fire) begin
			tot_q.cycle_sum    <= mem_sum[MEM_SUM_W] ? {MEM_SUM_W{1'b1}}
			                                         : mem_sum[MEM_SUM_W-1:0];
			tot_q.instructions <= sat_add32(tot_q.instructions, STAT_W'(ev.instr_count));
			tot_q.accesses     <= sat_add32(tot_q.accesses, STAT_W'(1));
			if (ev.hit && ev.is_store) begin
				tot_q.store_hit <= sat_add32(tot_q.store_hit, STAT_W'(1));
			end
			if (ev.hit && !ev.is_store) begin
				tot_q.load_hit <= sat_add32(tot_q.load_hit, STAT_W'(1));
			end
			if (!ev.hit && ev.is_store) begin
				tot_q.store_miss <= sat_add32(tot_q.store_miss, STAT_W'(1));
			end
			if (!ev.hit && !ev.is_store) begin
				tot_q.load_miss <= sat_add32(tot_q.load_miss, STAT_W'(1));
			end
			if (ev.write_back) begin
				tot_q.dirty_evict <= sat_add32(tot_q.dirty_evict, STAT_W'(1));
			end
		end
	end

	assign tot = tot_q;

endmodule

// ----- design/direct_mapped_writeback_cache_tags.sv -----
// ----------------------------------------------------------------------------
// direct_mapped_writeback_cache_tags
// direct-mapped write-back write-allocate tag store with saturating statistics
// ----------------------------------------------------------------------------
// datapath: an accepted command is registered in stage 1 while the tag ram is read,
//   then the stage 2 result registers load and done rises with the result
// throughput: one access per cycle while busy is low; the tag ram read-modify-write
//   forwards the last written line, so back-to-back accesses to one line need no stall
// reset: after arst_n releases, a clearing pass writes all 2**LINE_INDEX_BITS
//   tag entries with busy high; config is taken always
// the receiver cannot stall: each result is shown for exactly one cycle
module direct_mapped_writeback_cache_tags import dmc_pkg::*; #(
	parameter int LINE_INDEX_BITS = 10,
	parameter int ADDRESS_BITS    = 32
) (
	input  logic                  clk,
	input  logic                  arst_n,
	// command channel
	input  logic                  start,
	output logic                  busy,
	input  cmd_t                  cmd,
	// result channel
	output logic                  done,
	output result_t               result,
	// configuration write channel
	input  logic                  cfg_valid,
	output logic                  cfg_ready,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data
);

	localparam int DEPTH   = 1 << LINE_INDEX_BITS;
	// offset is at least two bits, so the tag never needs the top two bits
	localparam int TAG_W   = ADDRESS_BITS - 2;
	// entry layout: {valid, dirty, tag}
	localparam int ENTRY_W = TAG_W + 2;
	localparam int VLD_BIT = ENTRY_W - 1;
	localparam int DRT_BIT = ENTRY_W - 2;
	localparam int MASK_W  = LINE_INDEX_BITS + 1;
	localparam int IB_W    = $clog2(LINE_INDEX_BITS + 1);
	localparam int SH_W    = 6;

	// ---------------- configuration registers
	logic [2:0] block_offset_q;
	logic [3:0] index_bits_q;
	logic [9:0] penalty_q;

	// config is only to be written while idle; the block does not enforce this, so it is always taken
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			block_offset_q <= RST_BLOCK_OFFSET;
			index_bits_q   <= RST_INDEX_BITS;
			penalty_q      <= RST_MISS_PENALTY;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				CFG_BLOCK_OFFSET: block_offset_q <= cfg_data[2:0];
				CFG_INDEX_BITS:   index_bits_q   <= cfg_data[3:0];
				CFG_MISS_PENALTY: penalty_q      <= cfg_data[9:0];
				default: ;
			endcase
		end
	end

	// ---------------- clearing pass after reset
	logic                       clearing_q;
	logic [LINE_INDEX_BITS-1:0] clr_cnt_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clearing_q <= 1'b1;
			clr_cnt_q  <= '0;
		end else if (clearing_q) begin
			clr_cnt_q <= clr_cnt_q + LINE_INDEX_BITS'(1);
			if (clr_cnt_q == LINE_INDEX_BITS'(DEPTH - 1)) begin
				clearing_q <= 1'b0;
			end
		end
	end

	assign busy = clearing_q;

	logic accept;
	assign accept = start && !busy;

	// ---------------- address split (stage 0)
	logic [2:0]                 off_eff;
	logic [IB_W-1:0]            ib_eff;
	logic [ADDRESS_BITS-1:0]    addr_a;
	logic [MASK_W-1:0]          one_sh;
	logic [LINE_INDEX_BITS-1:0] idx_mask;
	logic [ADDRESS_BITS-1:0]    addr_sh;
	logic [SH_W-1:0]            tag_sh;
	logic [LINE_INDEX_BITS-1:0] line_now;
	logic [TAG_W-1:0]           tag_now;

	always_comb begin
		off_eff  = (block_offset_q < MIN_OFFSET_BITS) ? MIN_OFFSET_BITS : block_offset_q;
		ib_eff   = (32'(index_bits_q) > LINE_INDEX_BITS) ? IB_W'(LINE_INDEX_BITS)
		                                                 : IB_W'(index_bits_q);
		// bits at or above ADDRESS_BITS are dropped, missing ones read as zero
		addr_a   = ADDRESS_BITS'(cmd.byte_address);
		one_sh   = MASK_W'(1) << ib_eff;
		idx_mask = LINE_INDEX_BITS'(one_sh - MASK_W'(1));
		addr_sh  = addr_a >> off_eff;
		line_now = LINE_INDEX_BITS'(addr_sh) & idx_mask;
		tag_sh   = SH_W'(off_eff) + SH_W'(ib_eff);
		tag_now  = TAG_W'(addr_a >> tag_sh);
	end

	// ---------------- stage 1 registers, tag ram read in flight
	logic                       v_s1;
	logic                       is_store_s1;
	logic [LINE_INDEX_BITS-1:0] line_s1;
	logic [TAG_W-1:0]           tag_s1;
	logic [INSTR_CNT_W-1:0]     icount_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else begin
			v_s1 <= accept;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			is_store_s1 <= cmd.is_store;
			line_s1     <= line_now;
			tag_s1      <= tag_now;
			icount_s1   <= cmd.instr_count;
		end
	end

	// ---------------- tag ram
	logic                       ram_we;
	logic [LINE_INDEX_BITS-1:0] ram_waddr;
	logic [ENTRY_W-1:0]         ram_wdata;
	logic [ENTRY_W-1:0]         ram_rdata;
	logic [ENTRY_W-1:0]         new_entry;

	dmc_ram #(
		.WIDTH (ENTRY_W),
		.DEPTH (DEPTH)
	) u_tag_ram (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.raddr (line_now),
		.rdata (ram_rdata)
	);

	// clearing pass and lookups never overlap
	assign ram_we    = clearing_q || v_s1;
	assign ram_waddr = clearing_q ? clr_cnt_q : line_s1;
	assign ram_wdata = clearing_q ? '0 : new_entry;

	// ---------------- forwarding of the last written entry
	// the ram returns the old entry when the read meets a write to the same line
	logic                       fwd_v_q;
	logic [LINE_INDEX_BITS-1:0] fwd_line_q;
	logic [ENTRY_W-1:0]         fwd_entry_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fwd_v_q <= 1'b0;
		end else begin
			fwd_v_q <= v_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (v_s1) begin
			fwd_line_q  <= line_s1;
			fwd_entry_q <= new_entry;
		end
	end

	// ---------------- stage 1 lookup and update
	logic [ENTRY_W-1:0]   cur_entry;
	logic                 hit_now;
	logic                 wb_now;
	logic [ACC_CYC_W-1:0] cyc_now;

	always_comb begin
		cur_entry = (fwd_v_q && fwd_line_q == line_s1) ? fwd_entry_q : ram_rdata;
		hit_now   = cur_entry[VLD_BIT] && (cur_entry[TAG_W-1:0] == tag_s1);
		// a dirty victim is written back on a miss
		wb_now    = !hit_now && cur_entry[DRT_BIT];
		cyc_now   = '0;
		if (!hit_now) begin
			cyc_now = ACC_CYC_W'(penalty_q) + (wb_now ? WB_EXTRA_CYCLES : '0);
		end
		// allocate on miss; a store leaves the line dirty either way
		new_entry          = '0;
		new_entry[VLD_BIT] = 1'b1;
		new_entry[DRT_BIT] = is_store_s1 || (hit_now && cur_entry[DRT_BIT]);
		new_entry[TAG_W-1:0] = tag_s1;
	end

	// ---------------- statistics
	stat_ev_t  ev;
	stat_tot_t tot;

	always_comb begin
		ev.fire        = v_s1;
		ev.is_store    = is_store_s1;
		ev.hit         = hit_now;
		ev.write_back  = wb_now;
		ev.cycles      = cyc_now;
		ev.instr_count = icount_s1;
	end

	dmc_stats u_stats (
		.clk    (clk),
		.arst_n (arst_n),
		.ev     (ev),
		.tot    (tot)
	);

	// ---------------- stage 2 result registers
	logic                 done_q;
	logic                 hit_s2;
	logic                 wb_s2;
	logic [ACC_CYC_W-1:0] cyc_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done_q <= 1'b0;
		end else begin
			done_q <= v_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (v_s1) begin
			hit_s2 <= hit_now;
			wb_s2  <= wb_now;
			cyc_s2 <= cyc_now;
		end
	end

	assign done = done_q;

	always_comb begin
		result.hit                  = hit_s2;
		result.write_back           = wb_s2;
		result.access_cycles        = cyc_s2;
		result.cycle_total          = tot.cycle_sum;
		result.instr_sum            = tot.instructions;
		result.total_accesses       = tot.accesses;
		result.load_miss_count      = tot.load_miss;
		result.store_miss_count     = tot.store_miss;
		result.load_hit_count       = tot.load_hit;
		result.store_hit_count      = tot.store_hit;
		result.dirty_eviction_count = tot.dirty_evict;
	end

	// ---------------- assertions
	// no lookup may be in flight while the clearing pass owns the ram
	a_no_lookup_in_clear: assert property (@(posedge clk) disable iff (!arst_n)
		clearing_q |=> !v_s1)
		else $error("lookup issued during clearing pass");

	// a hit charges nothing, a write-back charges the penalty plus two
	a_hit_cycles: assert property (@(posedge clk) disable iff (!arst_n)
		done && result.hit |-> result.access_cycles == '0 && !result.write_back)
		else $error("hit charged memory cycles");

	a_wb_cycles: assert property (@(posedge clk) disable iff (!arst_n)
		done && result.write_back |->
			result.access_cycles == ACC_CYC_W'(penalty_q) + WB_EXTRA_CYCLES)
		else $error("write-back charge wrong");

	// a store always leaves the forwarded line valid and dirty
	a_store_dirty: assert property (@(posedge clk) disable iff (!arst_n)
		v_s1 && is_store_s1 |=> fwd_entry_q[DRT_BIT] && fwd_entry_q[VLD_BIT])
		else $error("store did not mark line dirty");

endmodule

// ----- sim/tb_direct_mapped_writeback_cache_tags.sv -----
// ----------------------------------------------------------------------------
// tb_direct_mapped_writeback_cache_tags
// self-checking bench: a driver feeds loads, stores and register writes from a
// queue, a behavioral copy of the tag store and counters predicts every result,
// and a monitor compares each strobed result field by field against it
// ----------------------------------------------------------------------------
module tb_direct_mapped_writeback_cache_tags;
	import dmc_pkg::*;

	localparam int CLK_PERIOD   = 8;
	localparam int RESET_CYCLES = 7;
	localparam int LINES_LOG2   = 10;
	localparam int LINES        = 1 << LINES_LOG2;
	// covers the clearing pass plus ~1.85k items with their idle gaps
	localparam int unsigned CYCLE_LIMIT = 100000;
	localparam int DRAIN_LIMIT  = 200;
	localparam int TAIL_CYCLES  = 8;
	localparam int RANDOM_PHASES    = 8;
	localparam int ITEMS_PER_PHASE  = 220;
	// closing run of back-to-back accesses with max instruction counts
	localparam int FINAL_ITEMS      = 70;

	// index with no register behind it, writes to it must be ignored
	localparam logic [CFG_IDX_W-1:0] CFG_UNUSED_IDX = 2'd3;

	typedef enum logic {ITEM_ACCESS, ITEM_REG_WRITE} item_kind_t;

	typedef struct {
		item_kind_t            kind;
		cmd_t                  access;
		logic [CFG_IDX_W-1:0]  reg_idx;
		logic [CFG_DATA_W-1:0] reg_val;
		int unsigned           gap;
	} stim_item_t;

	// dut ports; the inputs are driven to known values from time zero
	logic                  clk       = 1'b0;
	logic                  arst_n    = 1'b0;
	logic                  start     = 1'b0;
	cmd_t                  cmd       = '0;
	logic                  cfg_valid = 1'b0;
	logic [CFG_IDX_W-1:0]  cfg_index = '0;
	logic [CFG_DATA_W-1:0] cfg_data  = '0;
	logic                  busy;
	logic                  done;
	logic                  cfg_ready;
	result_t               result;

	// pending stimulus and predicted results in flight
	stim_item_t  pending_items [$];
	result_t     expected_results [$];

	// behavioral copy of the tag store
	bit [31:0]   line_tag   [LINES];
	bit          line_valid [LINES];
	bit          line_dirty [LINES];

	// register values as the block should see them
	logic [2:0]  cur_offset_bits = RST_BLOCK_OFFSET;
	logic [3:0]  cur_index_bits  = RST_INDEX_BITS;
	logic [9:0]  cur_penalty     = RST_MISS_PENALTY;

	// running totals as the block should report them
	logic [MEM_SUM_W-1:0] mem_total    = '0;
	logic [STAT_W-1:0]    instr_total  = '0;
	logic [STAT_W-1:0]    access_total = '0;
	logic [STAT_W-1:0]    ld_misses    = '0;
	logic [STAT_W-1:0]    st_misses    = '0;
	logic [STAT_W-1:0]    ld_hits      = '0;
	logic [STAT_W-1:0]    st_hits      = '0;
	logic [STAT_W-1:0]    evictions    = '0;

	// generator view of the address split, follows the queued register writes
	int unsigned gen_off = RST_BLOCK_OFFSET;
	int unsigned gen_ib  = RST_INDEX_BITS;
	bit          idle_mode = 1'b1;
	bit [31:0]   tag_pool  [4];
	bit [31:0]   line_pool [8];

	// bookkeeping
	int unsigned cycle_count       = 0;
	int unsigned accesses_queued   = 0;
	int unsigned accesses_accepted = 0;
	int unsigned reg_writes_done   = 0;
	int unsigned results_checked   = 0;
	int unsigned mismatch_count    = 0;
	int unsigned hits_predicted    = 0;
	int unsigned writebacks_predicted = 0;
	int unsigned peak_cycles       = 0;
	int unsigned gap_left          = 0;
	bit          gap_served        = 1'b0;

	direct_mapped_writeback_cache_tags #(
		.LINE_INDEX_BITS(LINES_LOG2),
		.ADDRESS_BITS   (32)
	) dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (start),
		.busy     (busy),
		.cmd      (cmd),
		.done     (done),
		.result   (result),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_index(cfg_index),
		.cfg_data (cfg_data)
	);

	always #(CLK_PERIOD / 2) clk = ~clk;

	// ------------------------------------------------------------------------
	// prediction
	// ------------------------------------------------------------------------

	// 32-bit running total that sticks at all ones
	function automatic logic [STAT_W-1:0] add_clamped(input logic [STAT_W-1:0] a,
	                                                  input logic [STAT_W-1:0] b);
		logic [STAT_W-1:0] s;
		s = a + b;
		return (s < a) ? '1 : s;
	endfunction

	task automatic apply_reg_write(input logic [CFG_IDX_W-1:0] idx,
	                               input logic [CFG_DATA_W-1:0] val);
		case (idx)
			CFG_BLOCK_OFFSET: cur_offset_bits = val[2:0];
			CFG_INDEX_BITS:   cur_index_bits  = val[3:0];
			CFG_MISS_PENALTY: cur_penalty     = val[9:0];
			default: ;
		endcase
	endtask

	// one lookup against the tag store copy; pushes the result it should give
	task automatic predict_access(input cmd_t c);
		int unsigned           off_w;
		int unsigned           idx_w;
		logic [LINES_LOG2-1:0] line;
		logic [31:0]           tg;
		logic [ACC_CYC_W-1:0]  cyc;
		logic [MEM_SUM_W:0]    sum;
		result_t               r;
		// offset below 2 bits acts as 2, index above the store size acts as full
		off_w = (cur_offset_bits < MIN_OFFSET_BITS) ? MIN_OFFSET_BITS : cur_offset_bits;
		idx_w = (cur_index_bits > LINES_LOG2) ? LINES_LOG2 : cur_index_bits;
		line  = LINES_LOG2'((c.byte_address >> off_w) & ((32'd1 << idx_w) - 32'd1));
		tg    = c.byte_address >> (off_w + idx_w);
		r     = '0;
		cyc   = '0;
		// stored tags survive reconfiguration and are compared as they are
		r.hit = line_valid[line] && (line_tag[line] == tg);
		if (r.hit) begin
			if (c.is_store) begin
				st_hits = add_clamped(st_hits, 1);
			end else begin
				ld_hits = add_clamped(ld_hits, 1);
			end
			hits_predicted++;
		end else begin
			cyc = ACC_CYC_W'(cur_penalty);
			if (line_dirty[line]) begin
				r.write_back = 1'b1;
				cyc = cyc + WB_EXTRA_CYCLES;
				evictions = add_clamped(evictions, 1);
				writebacks_predicted++;
			end
			line_tag[line]   = tg;
			line_valid[line] = 1'b1;
			line_dirty[line] = 1'b0;
			if (c.is_store) begin
				st_misses = add_clamped(st_misses, 1);
			end else begin
				ld_misses = add_clamped(ld_misses, 1);
			end
		end
		if (c.is_store) begin
			line_dirty[line] = 1'b1;
		end
		sum          = {1'b0, mem_total} + (MEM_SUM_W+1)'(cyc);
		mem_total    = sum[MEM_SUM_W] ? '1 : sum[MEM_SUM_W-1:0];
		instr_total  = add_clamped(instr_total, STAT_W'(c.instr_count));
		access_total = add_clamped(access_total, 1);
		if (32'(cyc) > peak_cycles) begin
			peak_cycles = 32'(cyc);
		end
		r.access_cycles        = cyc;
		r.cycle_total          = mem_total;
		r.instr_sum            = instr_total;
		r.total_accesses       = access_total;
		r.load_miss_count      = ld_misses;
		r.store_miss_count     = st_misses;
		r.load_hit_count       = ld_hits;
		r.store_hit_count      = st_hits;
		r.dirty_eviction_count = evictions;
		expected_results.push_back(r);
	endtask

	// ------------------------------------------------------------------------
	// stimulus generation
	// ------------------------------------------------------------------------

	task automatic queue_access(input bit st, input bit [31:0] addr, input bit [15:0] n);
		stim_item_t it;
		it.kind                = ITEM_ACCESS;
		it.access.is_store     = st;
		it.access.byte_address = addr;
		it.access.instr_count  = n;
		it.reg_idx             = '0;
		it.reg_val             = '0;
		// occasional idle bursts ahead of the access
		it.gap = (idle_mode && $urandom_range(0, 5) == 0) ? $urandom_range(1, 16) : 0;
		pending_items.push_back(it);
		accesses_queued++;
	endtask

	// unused upper data bits get random values, the block must ignore them
	task automatic queue_reg_write(input logic [CFG_IDX_W-1:0] idx, input int unsigned val);
		stim_item_t it;
		logic [CFG_DATA_W-1:0] data;
		data = CFG_DATA_W'($urandom);
		case (idx)
			CFG_BLOCK_OFFSET: begin
				data[2:0] = val[2:0];
				gen_off   = (val[2:0] < MIN_OFFSET_BITS) ? MIN_OFFSET_BITS : val[2:0];
			end
			CFG_INDEX_BITS: begin
				data[3:0] = val[3:0];
				gen_ib    = (val[3:0] > LINES_LOG2) ? LINES_LOG2 : val[3:0];
			end
			CFG_MISS_PENALTY: data = val[9:0];
			default: ;
		endcase
		it.kind    = ITEM_REG_WRITE;
		it.access  = '0;
		it.reg_idx = idx;
		it.reg_val = data;
		it.gap     = 0;
		pending_items.push_back(it);
	endtask

	task automatic refill_pools();
		foreach (tag_pool[i]) tag_pool[i] = $urandom;
		foreach (line_pool[i]) line_pool[i] = $urandom;
	endtask

	// mostly pooled tags and lines so hits, conflicts and write-backs recur; some use a
	// random line under a pooled tag, the rest are fully random addresses
	task automatic queue_random_access(input bit [15:0] n);
		int unsigned pick;
		bit [31:0]   ln;
		bit [31:0]   addr;
		pick = $urandom_range(0, 99);
		ln   = (pick < 80) ? line_pool[$urandom_range(0, 7)] : $urandom;
		addr = (tag_pool[$urandom_range(0, 3)] << (gen_off + gen_ib))
		     | ((ln & ((32'd1 << gen_ib) - 32'd1)) << gen_off)
		     | ($urandom & ((32'd1 << gen_off) - 32'd1));
		if (pick >= 88) begin
			addr = $urandom;
		end
		queue_access(1'($urandom_range(0, 1)), addr, n);
	endtask

	function automatic bit [15:0] draw_count();
		int unsigned pick;
		pick = $urandom_range(0, 9);
		return (pick == 0) ? 16'h0000 : (pick == 1) ? 16'hFFFF : 16'($urandom);
	endfunction

	// ------------------------------------------------------------------------
	// driver: one access or register write at a time from the pending queue
	// ------------------------------------------------------------------------
	always @(posedge clk) begin : drive_proc
		logic       nx_start;
		logic       nx_cfg_valid;
		stim_item_t head;
		if (arst_n) begin
			nx_start     = start;
			nx_cfg_valid = cfg_valid;
			// transactions completing at this edge
			if (start && !busy) begin
				predict_access(cmd);
				accesses_accepted++;
				nx_start = 1'b0;
			end
			if (cfg_valid && cfg_ready) begin
				apply_reg_write(cfg_index, cfg_data);
				reg_writes_done++;
				nx_cfg_valid = 1'b0;
			end
			// pick up the next item once both channels are free
			if (!nx_start && !nx_cfg_valid) begin
				if (gap_left != 0) begin
					gap_left--;
				end else if (pending_items.size() != 0) begin
					head = pending_items[0];
					if (head.kind == ITEM_REG_WRITE) begin
						// registers change only with nothing in flight
						if (expected_results.size() == 0 && !busy) begin
							cfg_index    <= head.reg_idx;
							cfg_data     <= head.reg_val;
							nx_cfg_valid = 1'b1;
							void'(pending_items.pop_front());
						end
					end else if (head.gap != 0 && !gap_served) begin
						gap_left   = head.gap - 1;
						gap_served = 1'b1;
					end else begin
						cmd        <= head.access;
						nx_start   = 1'b1;
						gap_served = 1'b0;
						void'(pending_items.pop_front());
					end
				end
			end
			start     <= nx_start;
			cfg_valid <= nx_cfg_valid;
		end
	end

	// ------------------------------------------------------------------------
	// monitor: every strobed result against the oldest prediction
	// ------------------------------------------------------------------------
	task automatic check_field(input string name, input logic [63:0] want,
	                           input logic [63:0] got);
		if (got !== want) begin
			mismatch_count++;
			if (mismatch_count <= 10) begin
				$display("result %0d: %s expected 0x%0h got 0x%0h",
				         results_checked, name, want, got);
			end
		end
	endtask

	always @(posedge clk) begin : monitor_proc
		result_t want;
		if (arst_n && done) begin
			if (expected_results.size() == 0) begin
				mismatch_count++;
				if (mismatch_count <= 10) begin
					$display("result %0d arrived with no access outstanding", results_checked);
				end
			end else begin
				want = expected_results.pop_front();
				check_field("hit", 64'(want.hit), 64'(result.hit));
				check_field("write_back", 64'(want.write_back), 64'(result.write_back));
				check_field("access_cycles", 64'(want.access_cycles),
				            64'(result.access_cycles));
				check_field("cycle_total", 64'(want.cycle_total), 64'(result.cycle_total));
				check_field("instr_sum", 64'(want.instr_sum), 64'(result.instr_sum));
				check_field("total_accesses", 64'(want.total_accesses),
				            64'(result.total_accesses));
				check_field("load_miss_count", 64'(want.load_miss_count),
				            64'(result.load_miss_count));
				check_field("store_miss_count", 64'(want.store_miss_count),
				            64'(result.store_miss_count));
				check_field("load_hit_count", 64'(want.load_hit_count),
				            64'(result.load_hit_count));
				check_field("store_hit_count", 64'(want.store_hit_count),
				            64'(result.store_hit_count));
				check_field("dirty_eviction_count", 64'(want.dirty_eviction_count),
				            64'(result.dirty_eviction_count));
			end
			results_checked++;
		end
	end

	// watchdog
	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("timeout after %0d cycles, %0d results outstanding",
			         cycle_count, expected_results.size());
			$display("direct_mapped_writeback_cache_tags regression: fail");
			$finish;
		end
	end

	// ------------------------------------------------------------------------
	// stimulus plan, reset and end of run
	// ------------------------------------------------------------------------
	initial begin : main_proc
		int unsigned phase_off [RANDOM_PHASES] = '{2, 7, 0, 5, 3, 1, 4, 6};
		int unsigned phase_ib  [RANDOM_PHASES] = '{10, 0, 15, 4, 1, 12, 7, 2};
		int unsigned phase_pen [RANDOM_PHASES] = '{1023, 0, 17, 300, 1, 512, 777, 1023};
		int unsigned drain;
		int unsigned leftover;

		// directed part under reset settings: 16-byte lines, 1024 lines, reset miss penalty
		queue_access(1'b0, 32'h0000_0000, 16'h0000);   // cold miss
		queue_access(1'b0, 32'h0000_0004, 16'hFFFF);   // load hit
		queue_access(1'b1, 32'h0000_000C, 16'h0001);   // store hit marks line dirty
		queue_access(1'b0, 32'h0000_4000, 16'h8000);   // conflict, dirty victim
		queue_access(1'b1, 32'hFFFF_FFFF, 16'hFFFF);   // top line, clean miss
		queue_access(1'b0, 32'hFFFF_FFF0, 16'h0000);   // load hit
		queue_access(1'b1, 32'h7FFF_FFF0, 16'h5555);   // dirty victim on top line
		queue_access(1'b1, 32'h7FFF_FFF8, 16'hAAAA);   // store hit
		queue_access(1'b0, 32'h8000_0000, 16'h0000);   // clean victim
		queue_access(1'b1, 32'hAAAA_AAAA, 16'hAAAA);
		queue_access(1'b0, 32'h5555_5555, 16'h5555);
		queue_access(1'b0, 32'hAAAA_AAA0, 16'h1234);   // hit on the same line

		// offset below minimum, single line, no penalty; old tags stay in place
		queue_reg_write(CFG_BLOCK_OFFSET, 0);
		queue_reg_write(CFG_INDEX_BITS, 0);
		queue_reg_write(CFG_MISS_PENALTY, 0);
		queue_reg_write(CFG_UNUSED_IDX, 10'h3FF);
		queue_access(1'b1, 32'h0000_0000, 16'h0F0F);   // miss against a stale tag
		queue_access(1'b0, 32'h0000_0003, 16'hF0F0);   // hit within the 4-byte line
		queue_access(1'b0, 32'h0000_0004, 16'h0000);   // write-back with zero penalty
		queue_access(1'b1, 32'hFFFF_FFFC, 16'hFFFF);   // widest tag
		queue_access(1'b0, 32'hFFFF_FFFF, 16'h0001);

		// largest offset, index above store size, largest penalty
		queue_reg_write(CFG_BLOCK_OFFSET, 7);
		queue_reg_write(CFG_INDEX_BITS, 15);
		queue_reg_write(CFG_MISS_PENALTY, 1023);
		queue_access(1'b1, 32'hDEAD_BEEF, 16'hBEEF);
		queue_access(1'b0, 32'hDEAD_BE80, 16'h0000);   // hit
		queue_access(1'b0, 32'h5EAD_BEEF, 16'h8001);   // largest access charge
		queue_access(1'b1, 32'h0000_0000, 16'hFFFF);

		// random phases, each under its own settings, idling in most of them
		for (int p = 0; p < RANDOM_PHASES; p++) begin
			queue_reg_write(CFG_BLOCK_OFFSET, phase_off[p]);
			queue_reg_write(CFG_INDEX_BITS, phase_ib[p]);
			queue_reg_write(CFG_MISS_PENALTY,
			                (p == 3 || p == 6) ? $urandom_range(0, 1023) : phase_pen[p]);
			refill_pools();
			idle_mode = (p % 3) != 2;
			repeat (ITEMS_PER_PHASE) queue_random_access(draw_count());
		end

		// last part: back-to-back accesses with max instruction counts
		queue_reg_write(CFG_BLOCK_OFFSET, $urandom_range(2, 7));
		queue_reg_write(CFG_INDEX_BITS, $urandom_range(1, 10));
		queue_reg_write(CFG_MISS_PENALTY, $urandom_range(0, 1023));
		refill_pools();
		idle_mode = 1'b0;
		repeat (FINAL_ITEMS) queue_random_access(16'hFFFF);

		// reset once, then let the clearing pass and the driver run
		repeat (RESET_CYCLES) @(posedge clk);
		arst_n <= 1'b1;

		while (accesses_accepted != accesses_queued) @(posedge clk);
		for (drain = 0; drain < DRAIN_LIMIT && expected_results.size() != 0; drain++) begin
			@(posedge clk);
		end
		// catch late or extra strobes
		repeat (TAIL_CYCLES) @(posedge clk);
		leftover = expected_results.size();
		if (leftover != 0) begin
			$display("%0d predicted results never arrived", leftover);
		end

		$display("checked %0d results over %0d register writes: %0d hits, %0d write-backs",
		         results_checked, reg_writes_done, hits_predicted, writebacks_predicted);
		$display("largest access charge %0d cycles, instruction total %s",
		         peak_cycles, (instr_total == '1) ? "pinned at its maximum" : "unsaturated");
		if (mismatch_count == 0 && leftover == 0) begin
			$display("direct_mapped_writeback_cache_tags regression: pass");
		end else begin
			$display("direct_mapped_writeback_cache_tags regression: fail");
		end
		$finish;
	end

endmodule

// ----- direct_mapped_writeback_cache_tags.f -----
design/dmc_pkg.sv
design/dmc_ram.sv
design/dmc_stats.sv
design/direct_mapped_writeback_cache_tags.sv
sim/tb_direct_mapped_writeback_cache_tags.sv
